FILE: src/drm_pkg.sv
// package for the des retail mac block: payload structs, des tables, helpers
// depends on nothing
`default_nettype none
package drm_pkg;

    typedef struct packed {
        logic [63:0] data_block;
        logic [3:0]  valid_bytes;
        logic        last_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] mac_value;
        logic        bad_length;
    } t_out_item;

    localparam logic CFG_KEY_ONE = 1'b0;
    localparam logic CFG_KEY_TWO = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_PAD,
        ST_DEC,
        ST_ENC,
        ST_OUT
    } t_state;

    // one des operation request to the core
    typedef struct packed {
        logic        start;
        logic        decrypt;
        logic [63:0] key;
        logic [63:0] blk;
    } t_des_req;

    localparam logic [7:0] IP_T [64] = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
    localparam logic [7:0] FP_T [64] = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
    localparam logic [7:0] E_T [48] = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
    localparam logic [7:0] P_T [32] = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
    localparam logic [7:0] PC1_T [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
        60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
        29,21,13,5,28,20,12,4};
    localparam logic [7:0] PC2_T [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
    // rounds with a single-bit key rotation
    localparam logic [15:0] ROT1 = 16'b1000_0001_0000_0011;

    localparam logic [3:0] SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] f_ip(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[64 - 32'(IP_T[i])];
        return y;
    endfunction

    function automatic logic [63:0] f_fp(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[64 - 32'(FP_T[i])];
        return y;
    endfunction

    function automatic logic [55:0] f_pc1(input logic [63:0] x);
        logic [55:0] y;
        for (int i = 0; i < 56; i++) y[55-i] = x[64 - 32'(PC1_T[i])];
        return y;
    endfunction

    function automatic logic [47:0] f_pc2(input logic [55:0] x);
        logic [47:0] y;
        for (int i = 0; i < 48; i++) y[47-i] = x[56 - 32'(PC2_T[i])];
        return y;
    endfunction

    function automatic logic [31:0] f_feistel(input logic [31:0] r, input logic [47:0] sk);
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) e[47-i] = r[32 - 32'(E_T[i])];
        e = e ^ sk;
        for (int j = 0; j < 8; j++) begin
            six = e[42-6*j +: 6];
            s[28-4*j +: 4] = SBOX[j][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32 - 32'(P_T[i])];
        return p;
    endfunction

endpackage
`default_nettype wire

FILE: src/drm_des_core.sv
// iterative des unit: one round per cycle, 16 rounds per block
// depends on drm_pkg
`default_nettype none
module drm_des_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire drm_pkg::t_des_req i_req,
    output logic                   o_done,
    output logic [63:0]            o_result
);
    logic        r_busy, n_busy;
    logic [3:0]  r_round, n_round;
    logic        r_dec;
    logic [27:0] r_c, r_d, n_c, n_d;
    logic [31:0] r_l, r_r, n_l, n_r;
    logic        r_done;
    logic [63:0] r_result, n_result;

    logic [55:0] w_cd;
    logic [63:0] w_x;
    logic [27:0] w_c, w_d;
    logic [47:0] w_sk;
    logic [31:0] w_t;
    logic        w_one;

    always_comb begin
        w_cd     = drm_pkg::f_pc1(i_req.key);
        w_x      = drm_pkg::f_ip(i_req.blk);
        n_busy   = r_busy;
        n_round  = r_round;
        n_c      = r_c;
        n_d      = r_d;
        n_l      = r_l;
        n_r      = r_r;
        n_result = r_result;
        w_c      = r_c;
        w_d      = r_d;
        // encrypt rotates left before use, decrypt uses key then rotates right
        w_one    = drm_pkg::ROT1[r_dec ? 4'd15 - r_round : r_round];
        if (!r_dec) begin
            w_c = w_one ? {r_c[26:0], r_c[27]} : {r_c[25:0], r_c[27:26]};
            w_d = w_one ? {r_d[26:0], r_d[27]} : {r_d[25:0], r_d[27:26]};
        end
        w_sk = drm_pkg::f_pc2({w_c, w_d});
        w_t  = r_l ^ drm_pkg::f_feistel(r_r, w_sk);
        if (i_req.start && !r_busy) begin
            n_busy  = 1'b1;
            n_round = '0;
            n_c     = w_cd[55:28];
            n_d     = w_cd[27:0];
            n_l     = w_x[63:32];
            n_r     = w_x[31:0];
        end else if (r_busy) begin
            n_l = r_r;
            n_r = w_t;
            if (r_dec) begin
                // rotate right by the amount of the round being undone
                n_c = w_one ? {r_c[0], r_c[27:1]} : {r_c[1:0], r_c[27:2]};
                n_d = w_one ? {r_d[0], r_d[27:1]} : {r_d[1:0], r_d[27:2]};
            end else begin
                n_c = w_c;
                n_d = w_d;
            end
            n_round = r_round + 4'd1;
            if (r_round == 4'd15) begin
                n_busy   = 1'b0;
                n_result = drm_pkg::f_fp({w_t, r_r});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && (r_round == 4'd15);
        end
        r_round  <= n_round;
        r_c      <= n_c;
        r_d      <= n_d;
        r_l      <= n_l;
        r_r      <= n_r;
        r_result <= n_result;
        if (i_req.start && !r_busy) r_dec <= i_req.decrypt;
    end

    assign o_done   = r_done;
    assign o_result = r_result;
endmodule
`default_nettype wire

FILE: src/drm_seq.sv
// sequencer for the retail mac: chaining, padding and final des steps
// depends on drm_pkg
`default_nettype none
module drm_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire drm_pkg::t_in_item  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output drm_pkg::t_out_item      out_data,
    input  wire logic [63:0]        i_key_one,
    input  wire logic [63:0]        i_key_two,
    output drm_pkg::t_des_req       o_req,
    input  wire logic               i_done,
    input  wire logic [63:0]        i_result
);
    drm_pkg::t_state    r_state, n_state;
    logic [63:0]        r_chain, n_chain;
    logic               r_pad, n_pad;
    logic               r_go, n_go;
    drm_pkg::t_out_item r_out, n_out;
    logic [3:0]         w_nv;
    logic [63:0]        w_keep, w_padv;

    always_comb begin
        w_nv   = (in_data.valid_bytes > 4'd8) ? 4'd8 : in_data.valid_bytes;
        w_keep = ~(64'hFFFF_FFFF_FFFF_FFFF >> {w_nv, 3'b000});
        w_padv = (w_nv == 4'd8) ? 64'd0 : (64'h80 << (7'd56 - {w_nv[2:0], 3'b000}));
        n_state = r_state;
        n_chain = r_chain;
        n_pad   = r_pad;
        n_go    = 1'b0;
        n_out   = r_out;
        o_req.start   = r_go;
        o_req.decrypt = (r_state == drm_pkg::ST_DEC);
        o_req.key     = (r_state == drm_pkg::ST_DEC) ? i_key_two : i_key_one;
        o_req.blk     = r_chain;
        in_ready  = (r_state == drm_pkg::ST_IDLE);
        out_valid = (r_state == drm_pkg::ST_OUT);
        out_data  = r_out;
        unique case (r_state)
            drm_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (!in_data.last_block && w_nv != 4'd8) begin
                        n_chain = '0;
                        n_out   = '{mac_value: '0, bad_length: 1'b1};
                        n_state = drm_pkg::ST_OUT;
                    end else begin
                        n_chain = r_chain ^ ((in_data.data_block & w_keep) | w_padv);
                        n_pad   = in_data.last_block && (w_nv == 4'd8);
                        n_go    = 1'b1;
                        n_state = in_data.last_block ? drm_pkg::ST_PAD : drm_pkg::ST_DATA;
                    end
                end
            end
            drm_pkg::ST_DATA: if (i_done) begin
                n_chain = i_result;
                n_state = drm_pkg::ST_IDLE;
            end
            drm_pkg::ST_PAD: if (i_done) begin
                n_go = 1'b1;
                if (r_pad) begin
                    n_chain = i_result ^ 64'h8000_0000_0000_0000;
                    n_pad   = 1'b0;
                end else begin
                    n_chain = i_result;
                    n_state = drm_pkg::ST_DEC;
                end
            end
            drm_pkg::ST_DEC: if (i_done) begin
                n_chain = i_result;
                n_go    = 1'b1;
                n_state = drm_pkg::ST_ENC;
            end
            drm_pkg::ST_ENC: if (i_done) begin
                n_out   = '{mac_value: i_result, bad_length: 1'b0};
                n_chain = '0;
                n_state = drm_pkg::ST_OUT;
            end
            drm_pkg::ST_OUT: if (out_ready) n_state = drm_pkg::ST_IDLE;
            default: n_state = drm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drm_pkg::ST_IDLE;
            r_chain <= '0;
            r_go    <= 1'b0;
            r_pad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chain <= n_chain;
            r_go    <= n_go;
            r_pad   <= n_pad;
        end
        r_out <= n_out;
    end
endmodule
`default_nettype wire

FILE: src/des_retail_mac_top.sv
// top level of the iso 9797-1 algorithm 3 retail mac
// depends on drm_pkg, drm_seq, drm_des_core
//
// channel | direction | payload             | handshake
// in      | in        | drm_pkg::t_in_item  | in_valid / in_ready
// out     | out       | drm_pkg::t_out_item | out_valid / out_ready
// cfg     | in        | index + 64-bit key  | cfg_valid / cfg_ready (always ready)
//
// each des pass runs on the shared round unit, with a handoff through the sequencer
// full non-last block: the next accept waits until its des pass is done
// last block: 3 passes (4 if aligned), then the result waits on out
// short non-last block: error result in the cycle after accept, no des pass
// reset clears chain, keys and sequencer; stalls on out hold the block
`default_nettype none
module des_retail_mac_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire drm_pkg::t_in_item  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output drm_pkg::t_out_item      out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);
    logic [63:0]       r_key_one, r_key_two;
    drm_pkg::t_des_req w_req;
    logic              w_done;
    logic [63:0]       w_result;

    assign cfg_ready = 1'b1;

    // key registers; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_one <= '0;
            r_key_two <= '0;
        end else if (cfg_valid && cfg_index[7:1] == 7'd0) begin
            if (cfg_index[0] == drm_pkg::CFG_KEY_ONE) r_key_one <= cfg_data;
            if (cfg_index[0] == drm_pkg::CFG_KEY_TWO) r_key_two <= cfg_data;
        end
    end

    drm_seq u_seq (
        .i_clk, .i_rst_n, .in_valid, .in_ready, .in_data,
        .out_valid, .out_ready, .out_data,
        .i_key_one(r_key_one), .i_key_two(r_key_two),
        .o_req(w_req), .i_done(w_done), .i_result(w_result)
    );

    drm_des_core u_des (
        .i_clk, .i_rst_n, .i_req(w_req), .o_done(w_done), .o_result(w_result)
    );
endmodule
`default_nettype wire

FILE: src/drm_checker.sv
// port-level checks for the retail mac top level
// depends on drm_pkg, des_retail_mac_top
`default_nettype none
module drm_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire drm_pkg::t_out_item out_data
);
    // never takes input while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("in ready while result pending");
    // error results carry a zero mac
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.bad_length |-> out_data.mac_value == 64'd0)
        else $error("bad length with nonzero mac");
    // busy right after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after accept");
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
endmodule

bind des_retail_mac_top drm_checker u_chk (
    .i_clk, .i_rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

FILE: test/des_retail_mac_top_tb.sv
// testbench for des_retail_mac_top: retail mac over random and directed messages
// depends on drm_pkg (payload types, des tables) and the des_retail_mac_top rtl
`default_nettype none
module des_retail_mac_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // config index that maps to no register, writes to it are dropped
    localparam logic [7:0] CFG_UNUSED = 8'd2;
    // cycles without any transaction before the run is declared hung
    localparam int HANG_LIMIT = 5000;
    // worst case in flight: four des passes
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 260;
    // key schedule left shifts per round
    localparam int KEY_SHIFT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_ready;
    drm_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    drm_pkg::t_out_item out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [7:0]         cfg_index;
    logic [63:0]        cfg_data;

    des_retail_mac_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // shadow state of the mac engine
    logic [63:0] key1_shadow;
    logic [63:0] key2_shadow;
    logic [63:0] chain_shadow;

    drm_pkg::t_out_item pending_macs [$];
    int        error_count;
    int        send_idle_pct;
    int        sink_stall_pct;
    int        hang_count;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------
    // single des block operation, built from the fips 46 tables
    // ---------------------------------------------------------------
    function automatic logic [31:0] round_func(input logic [31:0] r, input logic [47:0] sk);
        logic [47:0] ex;
        logic [31:0] sb;
        logic [31:0] pr;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) ex[47-i] = r[32 - int'(drm_pkg::E_T[i])];
        ex = ex ^ sk;
        for (int j = 0; j < 8; j++) begin
            six = ex[42-6*j +: 6];
            // row from the outer bits, column from the middle four
            sb[28-4*j +: 4] = drm_pkg::SBOX[j][int'({six[5], six[0]}) * 16 + int'(six[4:1])];
        end
        for (int i = 0; i < 32; i++) pr[31-i] = sb[32 - int'(drm_pkg::P_T[i])];
        return pr;
    endfunction

    function automatic logic [63:0] des_cipher(input logic [63:0] key, input logic [63:0] blk,
                                               input logic decrypt);
        logic [47:0] subkey [16];
        logic [55:0] cd;
        logic [55:0] cd_rot;
        logic [27:0] c;
        logic [27:0] d;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] rl;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(drm_pkg::PC1_T[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++) begin
            repeat (KEY_SHIFT[i]) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cd_rot = {c, d};
            for (int k = 0; k < 48; k++)
                subkey[i][47-k] = cd_rot[56 - int'(drm_pkg::PC2_T[k])];
        end
        for (int i = 0; i < 64; i++) x[63-i] = blk[64 - int'(drm_pkg::IP_T[i])];
        l = x[63:32];
        r = x[31:0];
        for (int i = 0; i < 16; i++) begin
            t = l ^ round_func(r, subkey[decrypt ? 15 - i : i]);
            l = r;
            r = t;
        end
        rl = {r, l};
        for (int i = 0; i < 64; i++) y[63-i] = rl[64 - int'(drm_pkg::FP_T[i])];
        return y;
    endfunction

    // cbc chaining step under key one
    function automatic void absorb_block(input logic [63:0] blk);
        chain_shadow = des_cipher(key1_shadow, chain_shadow ^ blk, 1'b0);
    endfunction

    // advances the shadow state by one block, returns 1 when a result is due
    function automatic bit compute_mac(input drm_pkg::t_in_item it,
                                       output drm_pkg::t_out_item res);
        int          nv;
        logic [63:0] keep;
        logic [63:0] pad;
        nv = (it.valid_bytes > 4'd8) ? 8 : int'(it.valid_bytes);
        res = '0;
        if (!it.last_block) begin
            if (nv == 8) begin
                absorb_block(it.data_block);
                return 0;
            end
            // short middle block: flagged, chain dropped
            chain_shadow = '0;
            res.bad_length = 1'b1;
            return 1;
        end
        if (nv == 8) begin
            absorb_block(it.data_block);
            absorb_block(64'h8000_0000_0000_0000);
        end else begin
            keep = (nv == 0) ? 64'd0 : (~64'd0 << (64 - 8 * nv));
            pad  = 64'h80 << (56 - 8 * nv);
            absorb_block((it.data_block & keep) | pad);
        end
        res.mac_value = des_cipher(key1_shadow, des_cipher(key2_shadow, chain_shadow, 1'b1), 1'b0);
        chain_shadow = '0;
        return 1;
    endfunction

    // ---------------------------------------------------------------
    // sender side: one transaction on the input channel
    // ---------------------------------------------------------------
    task automatic send_block(input drm_pkg::t_in_item it, input bit typed,
                              input drm_pkg::t_out_item typed_res);
        drm_pkg::t_out_item res;
        // random idle gap before the transaction
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge i_clk); while (!in_ready);
        if (compute_mac(it, res)) pending_macs.push_back(typed ? typed_res : res);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic write_key(input logic [7:0] idx, input logic [63:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge i_clk); while (!cfg_ready);
        if (idx == 8'(drm_pkg::CFG_KEY_ONE))      key1_shadow = value;
        else if (idx == 8'(drm_pkg::CFG_KEY_TWO)) key2_shadow = value;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // block idle: all macs out, plus time for a block that yields no transaction
    task automatic wait_idle;
        while (pending_macs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    // ---------------------------------------------------------------
    // result checker, sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        drm_pkg::t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_macs.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h/%b",
                                          out_data.mac_value, out_data.bad_length));
            end else begin
                want = pending_macs.pop_front();
                if (out_data.mac_value !== want.mac_value)
                    report_mismatch($sformatf("mac_value %h, expected %h",
                                              out_data.mac_value, want.mac_value));
                if (out_data.bad_length !== want.bad_length)
                    report_mismatch($sformatf("bad_length %b, expected %b",
                                              out_data.bad_length, want.bad_length));
            end
        end
    end

    // receiver stalls, changed at the falling edge
    always @(negedge i_clk) begin
        out_ready = ($urandom_range(99) >= sink_stall_pct);
    end

    // hang watchdog: counts cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            hang_count = 0;
        end else begin
            hang_count++;
            if (hang_count >= HANG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------
    typedef struct {
        drm_pkg::t_in_item  it;
        bit                 typed;
        drm_pkg::t_out_item res;
    } t_row;

    localparam drm_pkg::t_out_item LEN_ERR = '{mac_value: 64'd0, bad_length: 1'b1};
    localparam drm_pkg::t_out_item NO_RES  = '0;

    t_row directed [17] = '{
        // keys at reset value
        '{'{64'h0, 4'd8, 1'b1}, 0, NO_RES},                   // aligned, adds a pad block
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1}, 0, NO_RES}, // empty tail, pad only
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1}, 0, NO_RES},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1}, 0, NO_RES},
        '{'{64'h0123_4567_89AB_CDEF, 4'd8, 1'b0}, 0, NO_RES},
        '{'{64'hFEDC_BA98_7654_3210, 4'd15, 1'b1}, 0, NO_RES}, // count saturates
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0}, 1, LEN_ERR}, // zero-length middle
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b0}, 1, LEN_ERR},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0}, 0, NO_RES}, // saturated middle block
        '{'{64'h0, 4'd8, 1'b0}, 0, NO_RES},
        '{'{64'hA5A5_A5A5_A5A5_A5A5, 4'd4, 1'b1}, 0, NO_RES},
        // chain cleared by an error, then a fresh message
        '{'{64'h1111_2222_3333_4444, 4'd8, 1'b0}, 0, NO_RES},
        '{'{64'h5555_6666_7777_8888, 4'd3, 1'b0}, 1, LEN_ERR},
        '{'{64'h9999_AAAA_BBBB_CCCC, 4'd9, 1'b1}, 0, NO_RES},
        '{'{64'h8000_0000_0000_0001, 4'd1, 1'b0}, 1, LEN_ERR},
        '{'{64'h7FFF_FFFF_FFFF_FFFE, 4'd6, 1'b1}, 0, NO_RES},
        '{'{64'h0, 4'd2, 1'b1}, 0, NO_RES}
    };

    // random message: full middle blocks then a padded tail, sometimes broken
    task automatic send_random_message(inout int budget);
        drm_pkg::t_in_item it;
        int                nblk;
        nblk = $urandom_range(5);
        for (int b = 0; b < nblk && budget > 0; b++) begin
            it.data_block  = rand64();
            it.valid_bytes = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'd8;
            it.last_block  = 1'b0;
            // noise: a short middle block aborts the message
            if ($urandom_range(11) == 0) it.valid_bytes = 4'($urandom_range(7));
            send_block(it, 0, NO_RES);
            budget--;
            if (it.valid_bytes < 4'd8) return;
        end
        if (budget <= 0) return;
        it.data_block  = rand64();
        it.valid_bytes = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) :
                                                    4'($urandom_range(8, 1));
        it.last_block  = 1'b1;
        send_block(it, 0, NO_RES);
        budget--;
    endtask

    initial begin
        int budget;
        i_rst_n        = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        error_count    = 0;
        hang_count     = 0;
        key1_shadow    = '0;
        key2_shadow    = '0;
        chain_shadow   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed pass with keys at their reset value
        foreach (directed[k]) send_block(directed[k].it, directed[k].typed, directed[k].res);

        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_key(8'(drm_pkg::CFG_KEY_ONE), 64'hFFFF_FFFF_FFFF_FFFF);
                    write_key(8'(drm_pkg::CFG_KEY_TWO), 64'h0);
                    send_idle_pct = 0;  sink_stall_pct = 0;
                end
                1: begin
                    write_key(8'(drm_pkg::CFG_KEY_ONE), rand64());
                    write_key(8'(drm_pkg::CFG_KEY_TWO), rand64());
                    write_key(CFG_UNUSED, rand64());   // must leave both keys alone
                    send_idle_pct = 48; sink_stall_pct = 0;
                end
                2: begin
                    write_key(8'(drm_pkg::CFG_KEY_ONE), 64'h0);
                    write_key(8'(drm_pkg::CFG_KEY_TWO), 64'hFFFF_FFFF_FFFF_FFFF);
                    send_idle_pct = 0;  sink_stall_pct = 48;
                end
                default: begin
                    write_key(8'(drm_pkg::CFG_KEY_ONE), rand64());
                    write_key(8'(drm_pkg::CFG_KEY_TWO), rand64());
                    send_idle_pct = 32; sink_stall_pct = 32;
                end
            endcase
            budget = RANDOM_ITEMS;
            while (budget > 0) begin
                // short bursts with no gaps at all inside every phase
                if ($urandom_range(7) == 0) begin
                    int saved;
                    saved = send_idle_pct;
                    send_idle_pct = 0;
                    send_random_message(budget);
                    send_idle_pct = saved;
                end else begin
                    send_random_message(budget);
                end
            end
        end

        while (pending_macs.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
